// File: rtl/hpte_pkg.sv
// Package: shared types and constants for the hashed page table engine.
`default_nettype none
package hpte_pkg;
  localparam int LOG_TABLE_BYTES_DEF = 16;
  localparam int ENTRIES_PER_GROUP = 8;
  localparam int HASH_BITS = 19;
  localparam int VSID_W = 24;
  localparam int PI_W = 16;
  localparam int API_W = 6;
  localparam int RPN_W = 20;
  // entry: valid, vsid, h, api, rpn, wimg, marked, pp
  localparam int ENTRY_W = 1 + VSID_W + 1 + API_W + RPN_W + 4 + 1 + 2;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0, FN_RESERVE = 2'd1, FN_COMMIT = 2'd2, FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_HIT = 2'd1, ST_MISS = 2'd2, ST_LOCKED = 2'd3
  } status_t;

  typedef struct packed {
    logic            valid;
    logic [VSID_W-1:0] vsid;
    logic            hbit;
    logic [API_W-1:0] api;
    logic [RPN_W-1:0] rpn;
    logic [3:0]      wimg;
    logic            marked;
    logic [1:0]      pp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request
    logic rd;        // issue read of slot (grp, way)
    logic grp;       // 0 primary, 1 secondary
    logic [2:0] way;
    logic wr_mark;   // mark slot held in datapath
    logic wr_commit; // write mapping into held slot
    logic hold_slot; // remember current read slot and its entry
    logic clr_mark;  // write step of the sweep at clear counter
    logic clr_zero;  // sweep writes zero entries
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic match;   // read data matches request for this group
    logic free;    // read data is neither valid nor marked
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/hashed_page_table_engine.sv
// Top level: hashed page table engine with stream channels and APB register.
// Usage: items enter on s_axis (func, segment id, address, WIMG, pp); one result
// item per request leaves on m_axis. One register, table_locked, at address 0.
// One item is worked at a time; s_axis_tready is low while it is.
// The table RAM is single port with registered read, one slot read per cycle.
// A lookup reads up to 16 slots; the next item can be taken once its result
// has been loaded into the output register.
// Reserve and commit search both groups for a mapping, then both for a free
// slot. A locked request answers without a search.
// A clear of all marks sweeps the table with a read and a write per entry.
// After reset the block zeroes the table with s_axis_tready low; register
// writes are taken throughout.
// The result sits in an output register; when the receiver stalls it holds,
// the next item is worked and its result waits in the controller until the
// register frees, with s_axis_tready low.
`default_nettype none
module hashed_page_table_engine #(
  parameter int LOG_TABLE_BYTES = hpte_pkg::LOG_TABLE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] func, [25:2] segment_id, [26] use_address_segment,
  // [58:27] effective_address, [62:59] cache_attributes, [64:63] protection
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] status, [14:2] slot_index, [15] in_secondary_group,
  // [35:16] real_page_number, [39:36] entry_attributes,
  // [41:40] entry_protection, [57:42] page_index
  output logic [63:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hpte_pkg::*;
  localparam int IDX_W = LOG_TABLE_BYTES - 3;
  localparam logic [1:0] REG_LOCK = 2'd0;
  ctl_t ctl;
  stat_t stat;
  logic clr_en, busy, out_load, res_entry, res_slot, slot_grp, in_fire, locked;
  status_t res_status;
  logic [IDX_W-1:0] clr_addr, slot;
  entry_t ent;
  logic [PI_W-1:0] pi;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) locked <= 1'b0;
    else if (psel && penable && pwrite && paddr == REG_LOCK) locked <= pwdata[0];
  end
  assign prdata = (paddr == REG_LOCK) ? {31'd0, locked} : 32'd0;

  assign s_axis_tready = !busy && !rst;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  hpte_datapath #(.LOG_TABLE_BYTES(LOG_TABLE_BYTES)) u_dp (
    .clk(clk), .ctl(ctl), .clr_en(clr_en), .clr_addr(clr_addr),
    .segment_id(s_axis_tdata[25:2]), .use_address_segment(s_axis_tdata[26]),
    .effective_address(s_axis_tdata[58:27]), .cache_attributes(s_axis_tdata[62:59]),
    .protection(s_axis_tdata[64:63]), .stat(stat), .slot(slot),
    .slot_grp(slot_grp), .ent(ent), .pi(pi)
  );

  hpte_ctrl #(.LOG_TABLE_BYTES(LOG_TABLE_BYTES)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .func_in(s_axis_tdata[1:0]),
    .locked(locked), .out_free(!m_axis_tvalid || m_axis_tready), .stat(stat),
    .ctl(ctl), .clr_en(clr_en), .clr_addr(clr_addr), .busy(busy),
    .out_load(out_load), .res_status(res_status), .res_entry(res_entry),
    .res_slot(res_slot)
  );

  // result register loads when the controller leaves its output state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata <= {6'd0, pi,
                       res_entry ? ent.pp : 2'd0,
                       res_entry ? ent.wimg : 4'd0,
                       res_entry ? ent.rpn : 20'd0,
                       res_slot && slot_grp,
                       res_slot ? 13'(slot) : 13'd0,
                       res_status};
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid && !m_axis_tready
    |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  assert property (@(posedge clk) disable iff (rst) in_fire |=> busy)
    else $error("accepted item not worked");
  assert property (@(posedge clk) disable iff (rst) m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid)
    else $error("result dropped under stall");
endmodule
`default_nettype wire

// File: rtl/hpte_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module hpte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/hpte_datapath.sv
// Datapath: request registers, hash, table RAM, match logic, result fields.
`default_nettype none
module hpte_datapath #(
  parameter int LOG_TABLE_BYTES = hpte_pkg::LOG_TABLE_BYTES_DEF,
  localparam int IDX_W = LOG_TABLE_BYTES - 3
) (
  input  wire logic                 clk,
  input  wire hpte_pkg::ctl_t       ctl,
  input  wire logic                 clr_en,
  input  wire logic [IDX_W-1:0]     clr_addr,
  input  wire logic [23:0]          segment_id,
  input  wire logic                 use_address_segment,
  input  wire logic [31:0]          effective_address,
  input  wire logic [3:0]           cache_attributes,
  input  wire logic [1:0]           protection,
  output hpte_pkg::stat_t           stat,
  output logic [IDX_W-1:0]          slot,
  output logic                      slot_grp,
  output hpte_pkg::entry_t          ent,
  output logic [hpte_pkg::PI_W-1:0] pi
);
  import hpte_pkg::*;
  localparam int GRP_W = IDX_W - 3;
  logic [HASH_BITS-1:0] h1, h;
  logic [VSID_W-1:0] vsid;
  logic [3:0] wimg;
  logic [1:0] pp;
  logic [IDX_W-1:0] addr, rd_idx_q;
  logic rd_grp_q;
  entry_t wentry, rdata;
  logic we;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vsid <= use_address_segment ? {20'd0, effective_address[31:28]} : segment_id;
      pi   <= effective_address[27:12];
      wimg <= cache_attributes;
      pp   <= protection;
    end
    if (ctl.rd) begin
      rd_idx_q <= addr;
      rd_grp_q <= ctl.grp;
    end
    // held slot: its index, group and entry as read, or as written on commit
    if (ctl.hold_slot) begin
      slot <= rd_idx_q;
      slot_grp <= rd_grp_q;
      ent <= rdata;
    end else if (ctl.wr_commit) begin
      ent <= wentry;
    end
  end

  assign h1 = {3'd0, vsid[PI_W-1:0] ^ pi} | {vsid[HASH_BITS-1:PI_W], {PI_W{1'b0}}};
  always_comb begin
    h = ctl.grp ? ~h1 : h1;
    addr = {h[GRP_W-1:0], ctl.way};
    wentry = ent;
    we = 1'b0;
    if (clr_en) begin
      addr = clr_addr;
      if (ctl.clr_zero) wentry = '0;
      else wentry = rdata;
      wentry.marked = 1'b0;
      we = ctl.clr_mark;
    end else if (ctl.wr_mark || ctl.wr_commit) begin
      addr = slot;
      we = 1'b1;
      wentry.hbit = slot_grp;
      wentry.marked = ctl.wr_mark;
      if (ctl.wr_commit) begin
        wentry.valid = 1'b1;
        wentry.vsid = vsid;
        wentry.api = pi[15:10];
        wentry.rpn = {vsid[3:0], pi};
        wentry.wimg = wimg;
        wentry.pp = pp;
      end
    end
  end

  hpte_ram #(.WIDTH(ENTRY_W), .DEPTH(1 << IDX_W)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wentry), .rdata(rdata)
  );

  assign stat.match = rdata.valid && rdata.vsid == vsid && rdata.api == pi[15:10]
                      && rdata.hbit == rd_grp_q;
  assign stat.free = !rdata.valid && !rdata.marked;
endmodule
`default_nettype wire

// File: rtl/hpte_ctrl.sv
// Controller: sequences search, slot take, write and mark sweep.
`default_nettype none
module hpte_ctrl #(
  parameter int LOG_TABLE_BYTES = hpte_pkg::LOG_TABLE_BYTES_DEF,
  localparam int IDX_W = LOG_TABLE_BYTES - 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_fire,
  input  wire logic [1:0]       func_in,
  input  wire logic             locked,
  input  wire logic             out_free,
  input  wire hpte_pkg::stat_t  stat,
  output hpte_pkg::ctl_t        ctl,
  output logic                  clr_en,
  output logic [IDX_W-1:0]      clr_addr,
  output logic                  busy,
  output logic                  out_load,
  output hpte_pkg::status_t     res_status,
  output logic                  res_entry,  // report entry fields
  output logic                  res_slot    // report slot and group
);
  import hpte_pkg::*;
  typedef enum logic [2:0] {
    S_IDLE, S_CLRINIT, S_SRCH, S_TAKE, S_WR, S_OUT, S_SWEEP
  } state_t;
  state_t state;
  func_t func;
  logic [4:0] cnt;     // issued read count, bit3 = group
  logic       pend;    // a read result is valid this cycle
  logic [3:0] pcnt;
  logic       clr_rd;  // sweep: 0 read, 1 write

  always_comb begin
    ctl = '0;
    ctl.grp = cnt[3];
    ctl.way = cnt[2:0];
    ctl.load = in_fire;
    ctl.rd = (state == S_SRCH || state == S_TAKE) && !cnt[4];
    ctl.hold_slot = pend && ((state == S_TAKE && stat.free) ||
                             (state == S_SRCH && stat.match));
    ctl.wr_mark = state == S_WR && func == FN_RESERVE;
    ctl.wr_commit = state == S_WR && func == FN_COMMIT;
    ctl.clr_mark = clr_rd;
    ctl.clr_zero = state == S_CLRINIT;
    clr_en = state == S_SWEEP || state == S_CLRINIT;
    out_load = state == S_OUT && out_free;
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLRINIT;
      clr_addr <= '0;
      clr_rd <= 1'b0;
      cnt <= '0;
      pend <= 1'b0;
    end else begin
      pend <= ctl.rd;
      pcnt <= cnt[3:0];
      if (ctl.rd) cnt <= cnt + 5'd1;
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            func <= func_t'(func_in);
            res_entry <= 1'b0; res_slot <= 1'b0;
            cnt <= '0;
            if (func_t'(func_in) == FN_CLEAR) begin
              clr_addr <= '0; clr_rd <= 1'b0;
              res_status <= ST_DONE;
              state <= S_SWEEP;
            end else if (func_t'(func_in) != FN_LOOKUP && locked) begin
              res_status <= ST_LOCKED;
              state <= S_OUT;
            end else begin
              state <= S_SRCH;
            end
          end
        end
        S_CLRINIT, S_SWEEP: begin
          // reset: write zero entries; clear: read-modify-write
          clr_rd <= !clr_rd;
          if (clr_rd) begin
            clr_addr <= clr_addr + IDX_W'(1);
            if (&clr_addr) state <= (state == S_CLRINIT) ? S_IDLE : S_OUT;
          end
        end
        S_SRCH: begin
          if (pend && stat.match) begin
            res_status <= ST_HIT; res_entry <= 1'b1; res_slot <= 1'b1;
            state <= S_OUT;
          end else if (pend && pcnt == 4'hf) begin
            if (func == FN_LOOKUP) begin
              res_status <= ST_MISS; state <= S_OUT;
            end else begin
              cnt <= '0; state <= S_TAKE;
            end
          end
        end
        S_TAKE: begin
          if (pend && stat.free) begin
            res_slot <= 1'b1;
            res_status <= ST_DONE;
            state <= S_WR;
          end else if (pend && pcnt == 4'hf) begin
            res_status <= ST_MISS; state <= S_OUT;
          end
        end
        S_WR: begin
          if (func == FN_COMMIT) res_entry <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (rst) ctl.wr_mark |-> !ctl.wr_commit)
    else $error("mark and commit together");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> $past(state) == S_TAKE)
    else $error("write without free slot");
endmodule
`default_nettype wire
